### sv/qrr_pkg.sv
// shared constants for the quadratic real roots unit
`timescale 1ns / 1ps
package qrr_pkg;
  localparam logic [1:0] ST_TWO  = 2'd0;
  localparam logic [1:0] ST_ONE  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_AZERO = 2'd3;
endpackage

### sv/quadratic_real_roots_unit.sv
// top level: discriminant, square root and two dividers in one stall-able pipeline
// throughput: one item per cycle; the whole pipe advances when the output is free
// a stall freezes every stage together, valid bits follow the data
// reset clears the valid bits only, data registers are not reset
`timescale 1ns / 1ps
module quadratic_real_roots_unit import qrr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,  // coef_a, coef_b, coef_c
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o   // root_status, root_first, root_second, saturated, pad
);
  localparam int DL = 66 + FRAC_BITS;
  localparam int LAT = 3 + 1 + 32 + 1 + 1 + DL + 1;

  logic en;
  logic [LAT-1:0] vld_q;
  assign en = ~vld_q[LAT-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
  end

  // stage 1: products
  logic signed [31:0] a_q, b_q;
  logic [63:0] bsq_q;
  logic signed [63:0] ac_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= s_axis_tdata_i[31:0];
      b_q   <= s_axis_tdata_i[63:32];
      bsq_q <= 64'($signed(s_axis_tdata_i[63:32]) * $signed(s_axis_tdata_i[63:32]));
      ac_q  <= $signed(s_axis_tdata_i[31:0]) * $signed(s_axis_tdata_i[95:64]);
    end
  end
  // stage 2: quarter discriminant
  logic signed [31:0] a2_q, b2_q;
  logic signed [64:0] dq_q;
  logic [1:0] rb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q <= a_q; b2_q <= b_q;
      rb_q <= bsq_q[1:0];
      dq_q <= $signed({3'b0, bsq_q[63:2]}) - 65'(ac_q);
    end
  end
  // stage 3: classify
  logic signed [31:0] a3_q, b3_q;
  logic [1:0] st3_q;
  logic [63:0] dqu_q;
  logic rb3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= a2_q; b3_q <= b2_q; rb3_q <= rb_q[0];
      dqu_q <= dq_q[64] ? 64'd0 : dq_q[63:0];
      if (a2_q == 0) st3_q <= ST_AZERO;
      else if (dq_q[64]) st3_q <= ST_NONE;
      else if (dq_q == 0 && rb_q == 2'd0) st3_q <= ST_ONE;
      else st3_q <= ST_TWO;
    end
  end

  logic [31:0] sq;
  logic [33:0] sqr;
  qrr_sqrt u_sqrt (.clk_i, .en_i(en), .val_i(dqu_q), .root_o(sq), .rem_o(sqr));

  logic signed [31:0] ad_q [0:32];
  logic signed [31:0] bd_q [0:32];
  logic [1:0] sd_q [0:32];
  logic rd_q [0:32];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ad_q[0] <= a3_q; bd_q[0] <= b3_q; sd_q[0] <= st3_q; rd_q[0] <= rb3_q;
      for (int k = 0; k < 32; k++) begin
        ad_q[k+1] <= ad_q[k]; bd_q[k+1] <= bd_q[k];
        sd_q[k+1] <= sd_q[k]; rd_q[k+1] <= rd_q[k];
      end
    end
  end

  // numerator stage: s = 2q or 2q+1
  logic [33:0] lim;
  logic [33:0] s;
  assign lim = {2'b0, sq} + {33'b0, ~rd_q[32]};
  assign s = {1'b0, sq, 1'b0} + {33'b0, (sqr >= lim)};
  logic signed [34:0] n1, n2;
  always_comb begin
    if (sd_q[32] == ST_ONE) begin
      n1 = -35'(bd_q[32]);
      n2 = n1;
    end else begin
      n1 = -35'(bd_q[32]) + $signed({1'b0, s});
      n2 = -35'(bd_q[32]) - $signed({1'b0, s});
    end
  end
  logic signed [34:0] n1_q, n2_q;
  logic signed [32:0] dn_q;
  logic [1:0] s4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= n1; n2_q <= n2; s4_q <= sd_q[32];
      dn_q <= 33'(ad_q[32]) <<< 1;
    end
  end

  logic [32:0] dmag;
  assign dmag = dn_q[32] ? 33'(-dn_q) : dn_q;
  logic [31:0] q1, q2;
  logic sat1, sat2;
  qrr_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (.clk_i, .en_i(en),
    .num_i(66'(n1_q[34] ? -n1_q : n1_q)), .num_neg_i(n1_q[34]),
    .den_i(dmag), .den_neg_i(dn_q[32]), .quo_o(q1), .sat_o(sat1));
  qrr_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (.clk_i, .en_i(en),
    .num_i(66'(n2_q[34] ? -n2_q : n2_q)), .num_neg_i(n2_q[34]),
    .den_i(dmag), .den_neg_i(dn_q[32]), .quo_o(q2), .sat_o(sat2));

  logic [1:0] se_q [0:DL];
  always_ff @(posedge clk_i) begin
    if (en) begin
      se_q[0] <= s4_q;
      for (int k = 0; k < DL; k++) se_q[k+1] <= se_q[k];
    end
  end

  logic [71:0] out_q;
  logic ok;
  assign ok = se_q[DL] == ST_TWO || se_q[DL] == ST_ONE;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {5'b0, ok & (sat1 | sat2), ok ? q2 : 32'd0, ok ? q1 : 32'd0, se_q[DL]};
    end
  end
  assign m_axis_tdata_o = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped under stall");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_q[1:0] == ST_NONE || out_q[1:0] == ST_AZERO)
    |-> out_q[65:2] == '0 && !out_q[66])
    else $error("nonzero roots without real roots");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_q[1:0] == ST_ONE |-> out_q[33:2] == out_q[65:34])
    else $error("single root mismatch");
endmodule

### sv/qrr_div.sv
// pipelined restoring divider, one quotient bit per stage, with sign and clipping
`timescale 1ns / 1ps
module qrr_div import qrr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [65:0] num_i,
  input  logic        num_neg_i,
  input  logic [32:0] den_i,
  input  logic        den_neg_i,
  output logic [31:0] quo_o,
  output logic        sat_o
);
  localparam int NW = 66 + FRAC_BITS;
  localparam int QW = NW;
  logic [NW-1:0] n_q [0:QW];
  logic [33:0]   r_q [0:QW];
  logic [32:0]   d_q [0:QW];
  logic [QW-1:0] qb_q [0:QW];
  logic          ng_q [0:QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]  <= {num_i, {FRAC_BITS{1'b0}}} >> 0;
      r_q[0]  <= '0;
      d_q[0]  <= den_i;
      qb_q[0] <= '0;
      ng_q[0] <= num_neg_i ^ den_neg_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [34:0] tr;
    logic [34:0] df;
    assign tr = {r_q[k], n_q[k][NW-1]};
    assign df = tr - {2'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]  <= n_q[k] << 1;
        r_q[k+1]  <= df[34] ? tr[33:0] : df[33:0];
        qb_q[k+1] <= {qb_q[k][QW-2:0], ~df[34]};
        d_q[k+1]  <= d_q[k];
        ng_q[k+1] <= ng_q[k];
      end
    end
  end

  logic [QW-1:0] q;
  logic          big;
  assign q = qb_q[QW];
  always_comb begin
    if (ng_q[QW]) begin
      big   = q > QW'(32'h8000_0000);
      quo_o = big ? 32'h8000_0000 : 32'(-q);
    end else begin
      big   = q > QW'(32'h7FFF_FFFF);
      quo_o = big ? 32'h7FFF_FFFF : q[31:0];
    end
    sat_o = big;
  end
endmodule

### sv/qrr_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module qrr_sqrt import qrr_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] val_i,
  output logic [31:0] root_o,
  output logic [33:0] rem_o
);
  logic [63:0] v_q [0:32];
  logic [31:0] s_q [0:32];
  logic [65:0] rm_q [0:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= val_i; s_q[0] <= '0; rm_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_st
    logic [65:0] tr;
    logic [65:0] tt;
    assign tr = {rm_q[k][63:0], v_q[k][63:62]};
    assign tt = {32'b0, s_q[k], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k+1] <= v_q[k] << 2;
        if (tr >= tt) begin
          rm_q[k+1] <= tr - tt;
          s_q[k+1]  <= {s_q[k][30:0], 1'b1};
        end else begin
          rm_q[k+1] <= tr;
          s_q[k+1]  <= {s_q[k][30:0], 1'b0};
        end
      end
    end
  end
  assign root_o = s_q[32];
  assign rem_o  = rm_q[32][33:0];
endmodule
